// ===== hw/rtl/cfir_pkg.sv =====
`timescale 1ns / 1ps

package cfir_pkg;

   // Operation codes carried by an input transaction.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Fixed field widths.
   localparam int ORDER_W   = 5;
   localparam int TAP_IDX_W = 5;
   localparam int COEFF_W   = 16;
   localparam int OUT_W     = 24;
   localparam int FRAC_BITS = 15;

   // Saturation limits of the result.
   localparam logic [OUT_W-1:0] OUT_MAX = 24'h7F_FFFF;
   localparam logic [OUT_W-1:0] OUT_MIN = 24'h80_0000;

   // Control broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic                        shift;
      logic                        clear;
      logic                        load;
      logic [TAP_IDX_W-1:0]        tap_index;
      logic signed [COEFF_W-1:0]   coeff_re;
      logic signed [COEFF_W-1:0]   coeff_im;
      logic [ORDER_W-1:0]          order;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/cfir_ifs.sv =====
`timescale 1ns / 1ps

// Input channel: samples and coefficient loads.
interface cfir_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                                   valid;
   logic                                   ready;
   logic                                   operation;
   logic signed [SAMPLE_BITS-1:0]          sample_re;
   logic signed [SAMPLE_BITS-1:0]          sample_im;
   logic                                   first_of_vector;
   logic [cfir_pkg::TAP_IDX_W-1:0]         tap_index;
   logic signed [cfir_pkg::COEFF_W-1:0]    coeff_re;
   logic signed [cfir_pkg::COEFF_W-1:0]    coeff_im;

   modport source (
      output valid, operation, sample_re, sample_im, first_of_vector,
             tap_index, coeff_re, coeff_im,
      input  ready
   );
   modport sink (
      input  valid, operation, sample_re, sample_im, first_of_vector,
             tap_index, coeff_re, coeff_im,
      output ready
   );
endinterface

// Result channel: filtered samples.
interface cfir_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cfir_pkg::OUT_W-1:0]      result_re;
   logic signed [cfir_pkg::OUT_W-1:0]      result_im;
   logic                                   saturated;

   modport source (
      output valid, result_re, result_im, saturated,
      input  ready
   );
   modport sink (
      input  valid, result_re, result_im, saturated,
      output ready
   );
endinterface

// ===== hw/rtl/complex_fir_filter_core.sv =====
`timescale 1ns / 1ps

// Complex FIR filter, direct form, built as a chain of MAX_TAPS cells.
// The req channel carries two kinds of transaction. A load writes one Q1.15
// complex coefficient into the cell named by tap_index and returns nothing;
// loads are taken one per cycle while no sample is in flight. A sample is
// shifted into the delay line (history cleared first when first_of_vector
// is set) and returns one rsp transaction: the sum over taps 0..filter_order
// of tap times delayed sample, shifted right by 15 and saturated to 24 bits.
// The partial sum walks through the chain one cell per cycle; after a sample,
// no new item is taken until its finished sum is in the output register.
// filter_order is written through csr_wr_en / csr_wr_data; the user must do
// so only while idle, as the block itself does not enforce this.
// Reset clears all coefficients, the history and filter_order.
// If the receiver stalls, the result is held in the output register and the
// finished sum waits at the end of the chain; req stays not ready until the
// result has been taken.

module complex_fir_filter_core #(
   parameter int MAX_TAPS    = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   cfir_req_if.sink                        req,
   cfir_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [cfir_pkg::ORDER_W-1:0]    csr_wr_data
);

   localparam int PROD_W = cfir_pkg::COEFF_W + SAMPLE_BITS + 1;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
   localparam int DONE   = MAX_TAPS + 1;
   localparam int CNT_W  = $clog2(MAX_TAPS + 2);

   logic [cfir_pkg::ORDER_W-1:0]       order_ff, order_in;
   logic                               busy_ff, busy_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [cfir_pkg::OUT_W-1:0]  res_re_ff, res_im_ff;
   logic                               sat_ff;
   logic signed [cfir_pkg::OUT_W-1:0]  rnd_re, rnd_im;
   logic                               rnd_sat;
   logic                               take_req, take_sample, take_load;
   logic                               done, fill_out;
   cfir_pkg::cell_ctl_type             ctl;

   // The tail's sample output has no neighbor to feed.
   logic signed [SAMPLE_BITS-1:0]      smp_re_chain [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0]      smp_im_chain [MAX_TAPS];
   logic signed [ACC_W-1:0]            acc_re_chain [MAX_TAPS];
   logic signed [ACC_W-1:0]            acc_im_chain [MAX_TAPS];

   // Handshake decode.
   assign req.ready   = !busy_ff;
   assign take_req    = req.valid && !busy_ff;
   assign take_sample = take_req && (req.operation == cfir_pkg::OP_SAMPLE);
   assign take_load   = take_req && (req.operation == cfir_pkg::OP_LOAD);
   assign done        = busy_ff && (cnt_ff == CNT_W'(DONE));
   assign fill_out    = done && (!rsp_valid_ff || rsp.ready);

   // Control broadcast to the cells.
   always_comb begin
      ctl.shift     = take_sample;
      ctl.clear     = req.first_of_vector;
      ctl.load      = take_load;
      ctl.tap_index = req.tap_index;
      ctl.coeff_re  = req.coeff_re;
      ctl.coeff_im  = req.coeff_im;
      ctl.order     = order_ff;
   end

   // Chain of cells: the delay line runs forward and so does the partial sum.
   for (genvar q = 0; q < MAX_TAPS; q++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] s_re_in, s_im_in;
      logic signed [ACC_W-1:0]       a_re_in, a_im_in;

      if (q == 0) begin : g_head
         assign s_re_in = req.sample_re;
         assign s_im_in = req.sample_im;
         assign a_re_in = '0;
         assign a_im_in = '0;
      end else begin : g_body
         assign s_re_in = smp_re_chain[q-1];
         assign s_im_in = smp_im_chain[q-1];
         assign a_re_in = acc_re_chain[q-1];
         assign a_im_in = acc_im_chain[q-1];
      end

      cfir_cell #(
         .CELL_IDX    (q),
         .SAMPLE_BITS (SAMPLE_BITS),
         .ACC_W       (ACC_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .smp_re_in  (s_re_in),
         .smp_im_in  (s_im_in),
         .acc_re_in  (a_re_in),
         .acc_im_in  (a_im_in),
         .smp_re_out (smp_re_chain[q]),
         .smp_im_out (smp_im_chain[q]),
         .acc_re_out (acc_re_chain[q]),
         .acc_im_out (acc_im_chain[q])
      );
   end

   // Scaling and saturation of the finished sum.
   cfir_round #(
      .ACC_W (ACC_W)
   ) u_round (
      .acc_re    (acc_re_chain[MAX_TAPS-1]),
      .acc_im    (acc_im_chain[MAX_TAPS-1]),
      .result_re (rnd_re),
      .result_im (rnd_im),
      .saturated (rnd_sat)
   );

   // Sequencer: counts the sum's walk down the chain, then hands it to the output.
   always_comb begin
      order_in     = csr_wr_en ? csr_wr_data : order_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take_sample) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (fill_out) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (fill_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         order_ff     <= order_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (fill_out) begin
         res_re_ff <= rnd_re;
         res_im_ff <= rnd_im;
         sat_ff    <= rnd_sat;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.result_re = res_re_ff;
   assign rsp.result_im = res_im_ff;
   assign rsp.saturated = sat_ff;

   // A sample transaction starts the walk from the first cell.
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> (busy_ff && (cnt_ff == '0)))
      else $error("sample transaction did not start the sequencer");

   // A result appears only after the sum has reached the end of the chain.
   a_result_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && (cnt_ff == CNT_W'(DONE))))
      else $error("result raised before the chain walk finished");

   // A coefficient load never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      take_load |=> !$rose(rsp_valid_ff))
      else $error("coefficient load produced a result");

   // The walk counter never passes its end value.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CNT_W'(DONE)))
      else $error("sequencer counter out of range");

endmodule

// ===== hw/rtl/cfir_cell.sv =====
`timescale 1ns / 1ps

module cfir_cell #(
   parameter int CELL_IDX    = 0,
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_W       = 38
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfir_pkg::cell_ctl_type         ctl,
   input  logic signed [SAMPLE_BITS-1:0]  smp_re_in,
   input  logic signed [SAMPLE_BITS-1:0]  smp_im_in,
   input  logic signed [ACC_W-1:0]        acc_re_in,
   input  logic signed [ACC_W-1:0]        acc_im_in,
   output logic signed [SAMPLE_BITS-1:0]  smp_re_out,
   output logic signed [SAMPLE_BITS-1:0]  smp_im_out,
   output logic signed [ACC_W-1:0]        acc_re_out,
   output logic signed [ACC_W-1:0]        acc_im_out
);

   localparam int MUL_W  = cfir_pkg::COEFF_W + SAMPLE_BITS;
   localparam int PROD_W = MUL_W + 1;

   logic signed [cfir_pkg::COEFF_W-1:0] tap_re_ff, tap_re_in;
   logic signed [cfir_pkg::COEFF_W-1:0] tap_im_ff, tap_im_in;
   logic signed [SAMPLE_BITS-1:0]       smp_re_ff, smp_re_in_nx;
   logic signed [SAMPLE_BITS-1:0]       smp_im_ff, smp_im_in_nx;
   logic signed [MUL_W-1:0]             m_rr, m_ii, m_ri, m_ir;
   logic signed [PROD_W-1:0]            prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0]            prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]             acc_re_ff, acc_re_in_nx;
   logic signed [ACC_W-1:0]             acc_im_ff, acc_im_in_nx;
   logic                                tap_hit;
   logic                                use_tap;

   assign tap_hit = ctl.load && (int'(ctl.tap_index) == CELL_IDX);
   assign use_tap = int'(ctl.order) >= CELL_IDX;

   // Coefficient slot and delay-line stage of this cell.
   always_comb begin
      tap_re_in = tap_re_ff;
      tap_im_in = tap_im_ff;
      if (tap_hit) begin
         tap_re_in = ctl.coeff_re;
         tap_im_in = ctl.coeff_im;
      end
      smp_re_in_nx = smp_re_ff;
      smp_im_in_nx = smp_im_ff;
      if (ctl.shift) begin
         // A new vector starts with empty history; the head cell still takes the sample.
         if (ctl.clear && (CELL_IDX != 0)) begin
            smp_re_in_nx = '0;
            smp_im_in_nx = '0;
         end else begin
            smp_re_in_nx = smp_re_in;
            smp_im_in_nx = smp_im_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_re_ff <= '0;
         tap_im_ff <= '0;
         smp_re_ff <= '0;
         smp_im_ff <= '0;
      end else begin
         tap_re_ff <= tap_re_in;
         tap_im_ff <= tap_im_in;
         smp_re_ff <= smp_re_in_nx;
         smp_im_ff <= smp_im_in_nx;
      end
   end

   // Complex product of the tap and the held sample.
   assign m_rr = tap_re_ff * smp_re_ff;
   assign m_ii = tap_im_ff * smp_im_ff;
   assign m_ri = tap_re_ff * smp_im_ff;
   assign m_ir = tap_im_ff * smp_re_ff;
   assign prod_re_in = {m_rr[MUL_W-1], m_rr} - {m_ii[MUL_W-1], m_ii};
   assign prod_im_in = {m_ri[MUL_W-1], m_ri} + {m_ir[MUL_W-1], m_ir};

   // The partial sum from the neighbor picks up this cell's product when the tap is in use.
   always_comb begin
      acc_re_in_nx = acc_re_in;
      acc_im_in_nx = acc_im_in;
      if (use_tap) begin
         acc_re_in_nx = acc_re_in + {{(ACC_W-PROD_W){prod_re_ff[PROD_W-1]}}, prod_re_ff};
         acc_im_in_nx = acc_im_in + {{(ACC_W-PROD_W){prod_im_ff[PROD_W-1]}}, prod_im_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      acc_re_ff  <= acc_re_in_nx;
      acc_im_ff  <= acc_im_in_nx;
   end

   assign smp_re_out = smp_re_ff;
   assign smp_im_out = smp_im_ff;
   assign acc_re_out = acc_re_ff;
   assign acc_im_out = acc_im_ff;

endmodule

// ===== hw/rtl/cfir_round.sv =====
`timescale 1ns / 1ps

module cfir_round #(
   parameter int ACC_W = 38
) (
   input  logic signed [ACC_W-1:0]              acc_re,
   input  logic signed [ACC_W-1:0]              acc_im,
   output logic signed [cfir_pkg::OUT_W-1:0]    result_re,
   output logic signed [cfir_pkg::OUT_W-1:0]    result_im,
   output logic                                 saturated
);

   localparam int OUT_W = cfir_pkg::OUT_W;
   localparam int SH_W  = ACC_W - cfir_pkg::FRAC_BITS;
   localparam int CMP_W = (SH_W > OUT_W + 1) ? SH_W : OUT_W + 1;

   logic signed [ACC_W-1:0] sh_re, sh_im;
   logic signed [CMP_W-1:0] ext_re, ext_im;
   logic                    fit_re, fit_im;

   // Arithmetic shift drops the fraction, rounding toward minus infinity.
   assign sh_re  = acc_re >>> cfir_pkg::FRAC_BITS;
   assign sh_im  = acc_im >>> cfir_pkg::FRAC_BITS;
   assign ext_re = CMP_W'(sh_re);
   assign ext_im = CMP_W'(sh_im);

   // The value fits when all bits above the output sign bit copy it.
   assign fit_re = (&ext_re[CMP_W-1:OUT_W-1]) || !(|ext_re[CMP_W-1:OUT_W-1]);
   assign fit_im = (&ext_im[CMP_W-1:OUT_W-1]) || !(|ext_im[CMP_W-1:OUT_W-1]);

   always_comb begin
      if (fit_re) begin
         result_re = ext_re[OUT_W-1:0];
      end else if (ext_re[CMP_W-1]) begin
         result_re = cfir_pkg::OUT_MIN;
      end else begin
         result_re = cfir_pkg::OUT_MAX;
      end
      if (fit_im) begin
         result_im = ext_im[OUT_W-1:0];
      end else if (ext_im[CMP_W-1]) begin
         result_im = cfir_pkg::OUT_MIN;
      end else begin
         result_im = cfir_pkg::OUT_MAX;
      end
   end

   assign saturated = !fit_re || !fit_im;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int     TAPS         = 32;
   localparam int     HIST         = TAPS - 1;
   localparam int     IDLE_GUARD   = TAPS + 8;
   localparam int     RANDOM_ITEMS = 1030;
   localparam longint RES_HI       = 64'sd8388607;
   localparam longint RES_LO       = -64'sd8388608;

   // One request transaction, either a sample or a coefficient load.
   typedef struct packed {
      logic                                op;
      logic signed [15:0]                  s_re;
      logic signed [15:0]                  s_im;
      logic                                first;
      logic [cfir_pkg::TAP_IDX_W-1:0]      idx;
      logic signed [cfir_pkg::COEFF_W-1:0] c_re;
      logic signed [cfir_pkg::COEFF_W-1:0] c_im;
   } req_item_type;

   // One filtered output sample.
   typedef struct packed {
      logic signed [cfir_pkg::OUT_W-1:0] re;
      logic signed [cfir_pkg::OUT_W-1:0] im;
      logic                              sat;
   } filt_out_type;

   // One line of the directed table: an order write or a transaction.
   typedef struct packed {
      logic                         is_order;
      logic [cfir_pkg::ORDER_W-1:0] order;
      req_item_type                 item;
      logic                         typed;
      filt_out_type                 want;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en;
   logic [cfir_pkg::ORDER_W-1:0] csr_wr_data;

   cfir_req_if #(.SAMPLE_BITS(16)) req_if ();
   cfir_rsp_if                     rsp_if ();

   complex_fir_filter_core #(
      .MAX_TAPS    (TAPS),
      .SAMPLE_BITS (16)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Filter model state: coefficients, delay line and the current order.
   logic signed [15:0]           tap_re  [TAPS];
   logic signed [15:0]           tap_im  [TAPS];
   logic signed [15:0]           hist_re [HIST];
   logic signed [15:0]           hist_im [HIST];
   logic [cfir_pkg::ORDER_W-1:0] cur_order;

   filt_out_type filtered_q [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           burst_left = 0;
   int           calm_left  = 0;
   int           ready_hold = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Biased toward the corners of a 16-bit word.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Load fields on a sample carry junk; the block must ignore them.
   function automatic req_item_type sample_item(input logic first);
      req_item_type it;
      it.op    = cfir_pkg::OP_SAMPLE;
      it.s_re  = pick_word();
      it.s_im  = pick_word();
      it.first = first;
      it.idx   = cfir_pkg::TAP_IDX_W'($urandom);
      it.c_re  = 16'($urandom);
      it.c_im  = 16'($urandom);
      return it;
   endfunction

   // Sample fields on a load carry junk as well.
   function automatic req_item_type load_item(input logic [cfir_pkg::TAP_IDX_W-1:0] idx);
      req_item_type it;
      it.op    = cfir_pkg::OP_LOAD;
      it.s_re  = 16'($urandom);
      it.s_im  = 16'($urandom);
      it.first = 1'($urandom);
      it.idx   = idx;
      it.c_re  = pick_word();
      it.c_im  = pick_word();
      return it;
   endfunction

   function automatic void store_tap(input req_item_type it);
      if (it.idx < TAPS) begin
         tap_re[it.idx] = it.c_re;
         tap_im[it.idx] = it.c_im;
      end
   endfunction

   // Computes one output sample and advances the delay line.
   // With 32 taps the shifted sum stays within 22 bits, so the clip never
   // fires in practice; the flag is still checked.
   function automatic filt_out_type filter_sample(input req_item_type it);
      longint       acc_re;
      longint       acc_im;
      longint       br;
      longint       bi;
      longint       xr;
      longint       xi;
      int           taps_used;
      int           k;
      filt_out_type res;
      if (it.first) begin
         for (k = 0; k < HIST; k++) begin
            hist_re[k] = '0;
            hist_im[k] = '0;
         end
      end
      taps_used = (cur_order > HIST) ? HIST : cur_order;
      xr = $signed(it.s_re);
      xi = $signed(it.s_im);
      br = tap_re[0];
      bi = tap_im[0];
      acc_re = br * xr - bi * xi;
      acc_im = br * xi + bi * xr;
      for (k = 1; k <= taps_used; k++) begin
         br = tap_re[k];
         bi = tap_im[k];
         xr = hist_re[k-1];
         xi = hist_im[k-1];
         acc_re += br * xr - bi * xi;
         acc_im += br * xi + bi * xr;
      end
      for (k = HIST - 1; k > 0; k--) begin
         hist_re[k] = hist_re[k-1];
         hist_im[k] = hist_im[k-1];
      end
      hist_re[0] = it.s_re;
      hist_im[0] = it.s_im;

      acc_re = acc_re >>> cfir_pkg::FRAC_BITS;
      acc_im = acc_im >>> cfir_pkg::FRAC_BITS;
      res.sat = 1'b0;
      if (acc_re > RES_HI) begin
         res.re  = cfir_pkg::OUT_MAX;
         res.sat = 1'b1;
      end else if (acc_re < RES_LO) begin
         res.re  = cfir_pkg::OUT_MIN;
         res.sat = 1'b1;
      end else begin
         res.re = acc_re[cfir_pkg::OUT_W-1:0];
      end
      if (acc_im > RES_HI) begin
         res.im  = cfir_pkg::OUT_MAX;
         res.sat = 1'b1;
      end else if (acc_im < RES_LO) begin
         res.im  = cfir_pkg::OUT_MIN;
         res.sat = 1'b1;
      end else begin
         res.im = acc_im[cfir_pkg::OUT_W-1:0];
      end
      return res;
   endfunction

   // Drives one request transaction in bursts with random gaps, then records
   // what it should produce once the handshake completes.
   task automatic send_item(input req_item_type it, input logic typed,
                            input filt_out_type want);
      int           gap;
      filt_out_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_if.valid           <= 1'b1;
      req_if.operation       <= it.op;
      req_if.sample_re       <= it.s_re;
      req_if.sample_im       <= it.s_im;
      req_if.first_of_vector <= it.first;
      req_if.tap_index       <= it.idx;
      req_if.coeff_re        <= it.c_re;
      req_if.coeff_im        <= it.c_im;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (it.op == cfir_pkg::OP_LOAD) begin
         store_tap(it);
      end else begin
         predicted = filter_sample(it);
         filtered_q.push_back(typed ? want : predicted);
      end
   endtask

   // Drops valid and lets every sample in flight drain out of the chain.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic write_order(input logic [cfir_pkg::ORDER_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_order = value;
   endtask

   // Builders for the directed table.
   task automatic dir_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic first, input logic typed,
                             input logic signed [23:0] w_re, input logic signed [23:0] w_im);
      stim_row_type row;
      row           = '0;
      row.item      = sample_item(first);
      row.item.s_re = re;
      row.item.s_im = im;
      row.typed     = typed;
      row.want.re   = w_re;
      row.want.im   = w_im;
      row.want.sat  = 1'b0;
      directed_rows.push_back(row);
   endtask

   task automatic dir_load(input logic [cfir_pkg::TAP_IDX_W-1:0] idx,
                           input logic signed [15:0] re, input logic signed [15:0] im);
      stim_row_type row;
      row           = '0;
      row.item      = load_item(idx);
      row.item.c_re = re;
      row.item.c_im = im;
      directed_rows.push_back(row);
   endtask

   task automatic dir_order(input logic [cfir_pkg::ORDER_W-1:0] value);
      stim_row_type row;
      row          = '0;
      row.is_order = 1'b1;
      row.order    = value;
      directed_rows.push_back(row);
   endtask

   // Result side: check each accepted transaction, then pick the next ready
   // value from a stall pattern with occasional long stall-free stretches.
   always @(posedge clock) begin : rsp_side
      filt_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (filtered_q.size() == 0) begin
            report_mismatch($sformatf("result %0d %0d arrived with nothing pending",
                                      rsp_if.result_re, rsp_if.result_im));
         end else begin
            want = filtered_q.pop_front();
            if (rsp_if.result_re !== want.re)
               report_mismatch($sformatf("result_re got %0d, expected %0d",
                                         rsp_if.result_re, want.re));
            if (rsp_if.result_im !== want.im)
               report_mismatch($sformatf("result_im got %0d, expected %0d",
                                         rsp_if.result_im, want.im));
            if (rsp_if.saturated !== want.sat)
               report_mismatch($sformatf("saturated got %0b, expected %0b",
                                         rsp_if.saturated, want.sat));
         end
      end

      if (calm_left != 0) begin
         calm_left--;
         rsp_if.ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold--;
      end else if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(40, 250);
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 3) != 0);
         ready_hold = $urandom_range(0, 5);
      end
   end

   initial begin : stimulus
      stim_row_type                 row;
      int                           k;
      int                           phase;
      int                           phase_items;
      int                           vec_len;
      int                           pos;
      logic                         first;
      logic [cfir_pkg::ORDER_W-1:0] next_order;

      // Every block input is known from time zero.
      req_if.valid           = 1'b0;
      req_if.operation       = cfir_pkg::OP_SAMPLE;
      req_if.sample_re       = '0;
      req_if.sample_im       = '0;
      req_if.first_of_vector = 1'b0;
      req_if.tap_index       = '0;
      req_if.coeff_re        = '0;
      req_if.coeff_im        = '0;
      rsp_if.ready           = 1'b0;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      for (k = 0; k < TAPS; k++) begin
         tap_re[k] = '0;
         tap_im[k] = '0;
      end
      for (k = 0; k < HIST; k++) begin
         hist_re[k] = '0;
         hist_im[k] = '0;
      end
      cur_order = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Order is zero out of reset and all taps are zero.
      dir_sample(16'sh7FFF, -16'sh8000, 1'b1, 1'b1, 24'sd0, 24'sd0);
      dir_load(5'd0, 16'sh7FFF, 16'sh0000);
      // Almost-unity tap zero: each part of the output is the input one LSB nearer zero.
      dir_sample(-16'sh8000, 16'sh7FFF, 1'b1, 1'b1, -24'sd32767, 24'sd32766);
      dir_load(5'd0, -16'sh8000, -16'sh8000);
      // Both parts at minus one: the real terms cancel, the imaginary add up.
      dir_sample(-16'sh8000, -16'sh8000, 1'b0, 1'b1, 24'sd0, 24'sd65536);
      dir_order(5'd31);
      dir_load(5'd31, -16'sh8000, 16'sh7FFF);
      dir_load(5'd1, 16'sd12345, -16'sd23456);
      // History from the samples above is still in the delay line.
      dir_sample(16'sd1000, -16'sd2000, 1'b0, 1'b0, '0, '0);
      dir_sample(-16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0, '0);
      dir_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, '0, '0);
      dir_sample(16'sd0, 16'sd0, 1'b0, 1'b0, '0, '0);
      dir_load(5'd16, 16'sd0, -16'sd1);
      dir_sample(-16'sd1, -16'sd1, 1'b0, 1'b0, '0, '0);
      dir_order(5'd1);
      dir_sample(16'sh7FFF, -16'sh8000, 1'b0, 1'b0, '0, '0);
      dir_sample(-16'sh8000, 16'sh7FFF, 1'b1, 1'b0, '0, '0);
      dir_load(5'd0, 16'sd0, 16'sd0);
      dir_sample(16'sd5, 16'sd5, 1'b0, 1'b0, '0, '0);
      dir_order(5'd0);
      dir_sample(-16'sh8000, -16'sh8000, 1'b0, 1'b0, '0, '0);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.is_order)
            write_order(row.order);
         else
            send_item(row.item, row.typed, row.want);
      end

      // Random part: phases, each with its own order and coefficient set,
      // then vectors of samples with random content. A few vectors start
      // without the first flag, a few carry a stray one, and loads sometimes
      // land in the middle of a vector.
      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         next_order = (phase == 0) ? 5'd31 :
                      (phase == 1) ? 5'd0  : cfir_pkg::ORDER_W'($urandom_range(0, 31));
         write_order(next_order);

         if (phase % 3 == 0) begin
            for (k = 0; k < TAPS; k++)
               send_item(load_item(cfir_pkg::TAP_IDX_W'(k)), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 8))
               send_item(load_item(cfir_pkg::TAP_IDX_W'($urandom)), 1'b0, '0);
         end

         phase_items = $urandom_range(60, 140);
         while (phase_items > 0 && items_sent < RANDOM_ITEMS) begin
            vec_len = $urandom_range(1, 48);
            for (pos = 0;
                 pos < vec_len && phase_items > 0 && items_sent < RANDOM_ITEMS;
                 pos++) begin
               if ($urandom_range(0, 23) == 0)
                  send_item(load_item(cfir_pkg::TAP_IDX_W'($urandom)), 1'b0, '0);
               first = (pos == 0) ? ($urandom_range(0, 15) != 0)
                                  : ($urandom_range(0, 19) == 0);
               send_item(sample_item(first), 1'b0, '0);
               phase_items--;
            end
         end
         phase++;
      end

      wait_idle();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
